@@ hw/rtl/nack_retransmit_frame_store_assert.svh @@
// Assertion macros for the port-level checker
`ifndef NACK_RETRANSMIT_FRAME_STORE_ASSERT_SVH
`define NACK_RETRANSMIT_FRAME_STORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define NRFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define NRFS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/nrfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_pkg
// Shared constants and types of the retransmission frame store.
// ----------------------------------------------------------------------------
package nrfs_pkg;

    localparam int SLOTS       = 512;
    localparam int FRAME_WORDS = 41;
    localparam int FIFO_DEPTH  = 2;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int FADDR_W = $clog2(SLOTS * FRAME_WORDS);
    localparam int KIDX_W  = $clog2(FRAME_WORDS);
    localparam int WIDX_W  = $clog2(FRAME_WORDS + 2);
    localparam int KEEP_W  = 10;
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(500);

    typedef enum logic [1:0] {
        OP_STORE  = 2'b01,
        OP_REPLAY = 2'b10
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] seq;
    } cmd_t;

    // Back part to front part: status and staging read port
    typedef struct packed {
        logic              init_done;
        logic              store_done;
        logic              stg_re;
        logic [KIDX_W-1:0] stg_addr;
    } back_stat_t;

    typedef struct packed {
        logic        vld;
        logic [31:0] seq;
    } slot_ent_t;

endpackage

@@ hw/rtl/nrfs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_front
// Accepts input items, stages frame words, checks frame length and
// queues store or replay requests for the back part.
// ----------------------------------------------------------------------------
module nrfs_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [31:0]               s_data_word,
    input  logic                      s_frame_end,
    input  logic                      fifo_full,
    output logic                      fifo_push,
    output nrfs_pkg::cmd_t            fifo_cmd,
    input  nrfs_pkg::back_stat_t      bstat,
    output logic [31:0]               stg_q
);

    logic [31:0]                   stg_mem [nrfs_pkg::FRAME_WORDS];
    logic [nrfs_pkg::WIDX_W-1:0]   widx_reg;
    logic [31:0]                   seq_reg;
    logic                          store_pend_reg;
    logic                          acc;
    logic                          stg_we;
    logic                          good_end;

    assign s_ready  = bstat.init_done && !fifo_full && !store_pend_reg;
    assign acc      = s_valid && s_ready;
    assign stg_we   = acc && !s_mode
                      && (widx_reg < nrfs_pkg::WIDX_W'(nrfs_pkg::FRAME_WORDS));
    assign good_end = acc && !s_mode && s_frame_end
                      && (widx_reg == nrfs_pkg::WIDX_W'(nrfs_pkg::FRAME_WORDS - 1));

    always_comb begin
        fifo_push    = 1'b0;
        fifo_cmd.op  = nrfs_pkg::OP_STORE;
        fifo_cmd.seq = seq_reg;
        if (acc && s_mode) begin
            fifo_push    = 1'b1;
            fifo_cmd.op  = nrfs_pkg::OP_REPLAY;
            fifo_cmd.seq = s_data_word;
        end else if (good_end) begin
            fifo_push = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_we) begin
            stg_mem[widx_reg[nrfs_pkg::KIDX_W-1:0]] <= s_data_word;
        end
        if (bstat.stg_re) begin
            stg_q <= stg_mem[bstat.stg_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg       <= '0;
            store_pend_reg <= 1'b0;
        end else begin
            if (acc && !s_mode) begin
                if (widx_reg == '0) begin
                    seq_reg <= s_data_word;
                end
                if (s_frame_end) begin
                    widx_reg <= '0;
                end else if (widx_reg <= nrfs_pkg::WIDX_W'(nrfs_pkg::FRAME_WORDS)) begin
                    widx_reg <= widx_reg + 1'b1;
                end
            end
            // hold the staging buffer until the back part has copied it
            if (good_end) begin
                store_pend_reg <= 1'b1;
            end else if (bstat.store_done) begin
                store_pend_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/nrfs_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_cmd_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module nrfs_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nrfs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output nrfs_pkg::cmd_t head
);

    localparam int PTR_W = (nrfs_pkg::FIFO_DEPTH > 1) ? $clog2(nrfs_pkg::FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(nrfs_pkg::FIFO_DEPTH + 1);

    nrfs_pkg::cmd_t      ent_reg [nrfs_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]    wp_reg;
    logic [PTR_W-1:0]    rp_reg;
    logic [FCNT_W-1:0]   cnt_reg;

    assign full      = (cnt_reg == FCNT_W'(nrfs_pkg::FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                ent_reg[wp_reg] <= push_cmd;
                wp_reg <= (wp_reg == PTR_W'(nrfs_pkg::FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PTR_W'(nrfs_pkg::FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/nrfs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_back
// Carries out requests: walks the slot table, stores and forwards frames,
// evicts the smallest sequence numbers and replays stored frames.
// ----------------------------------------------------------------------------
module nrfs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nrfs_pkg::KEEP_W-1:0]   cfg_wr_data,
    input  logic                          fifo_not_empty,
    input  nrfs_pkg::cmd_t                fifo_head,
    output logic                          fifo_pop,
    output nrfs_pkg::back_stat_t          bstat,
    input  logic [31:0]                   stg_q,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_out_word,
    output logic                          m_out_last,
    output logic                          m_is_replay
);

    localparam int SLOT_W  = nrfs_pkg::SLOT_W;
    localparam int FADDR_W = nrfs_pkg::FADDR_W;
    localparam int KIDX_W  = nrfs_pkg::KIDX_W;
    localparam int CNT_W   = nrfs_pkg::CNT_W;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_SCAN   = 10'b00_0000_0100,
        ST_DECIDE = 10'b00_0000_1000,
        ST_CPRD   = 10'b00_0001_0000,
        ST_CPLD   = 10'b00_0010_0000,
        ST_EVCHK  = 10'b00_0100_0000,
        ST_EVDEC  = 10'b00_1000_0000,
        ST_RPRD   = 10'b01_0000_0000,
        ST_RPLD   = 10'b10_0000_0000
    } state_t;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      clr_idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [nrfs_pkg::KEEP_W-1:0] keep_reg;
    nrfs_pkg::cmd_t         cmd_reg;
    logic                   evict_reg;
    logic [SLOT_W:0]        issue_reg;
    logic                   pipe_v_reg;
    logic [SLOT_W-1:0]      pipe_idx_reg;
    logic                   hit_v_reg;
    logic [SLOT_W-1:0]      hit_idx_reg;
    logic                   free_v_reg;
    logic [SLOT_W-1:0]      free_idx_reg;
    logic                   min_v_reg;
    logic [SLOT_W-1:0]      min_idx_reg;
    logic [31:0]            min_seq_reg;
    logic                   store_ok_reg;
    logic [FADDR_W-1:0]     base_reg;
    logic [KIDX_W-1:0]      k_reg;
    logic                   out_v_reg;
    logic [31:0]            out_word_reg;
    logic                   out_last_reg;
    logic                   out_replay_reg;

    // slot table and frame memory
    nrfs_pkg::slot_ent_t    slot_mem [nrfs_pkg::SLOTS];
    nrfs_pkg::slot_ent_t    slot_q;
    logic [31:0]            frame_mem [nrfs_pkg::SLOTS * nrfs_pkg::FRAME_WORDS];
    logic [31:0]            frame_q;

    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_waddr;
    nrfs_pkg::slot_ent_t    slot_wdata;
    logic                   slot_re;
    logic                   frame_we;
    logic                   frame_re;
    logic [FADDR_W-1:0]     frame_addr;

    logic                   load_ok;
    logic                   out_load;
    logic                   k_last;
    logic                   scan_done;
    logic                   sel_ok;
    logic                   sel_new;
    logic [SLOT_W-1:0]      sel_idx;
    logic [CNT_W-1:0]       lim;

    assign load_ok   = !out_v_reg || m_ready;
    assign out_load  = load_ok && ((state_reg == ST_CPLD) || (state_reg == ST_RPLD));
    assign k_last    = (k_reg == KIDX_W'(nrfs_pkg::FRAME_WORDS - 1));
    assign scan_done = (issue_reg == (SLOT_W+1)'(nrfs_pkg::SLOTS)) && !pipe_v_reg;
    assign frame_addr = base_reg + FADDR_W'(k_reg);

    assign m_valid     = out_v_reg;
    assign m_out_word  = out_word_reg;
    assign m_out_last  = out_last_reg;
    assign m_is_replay = out_replay_reg;

    assign fifo_pop = (state_reg == ST_IDLE) && fifo_not_empty;

    assign bstat.init_done  = (state_reg != ST_CLEAR);
    assign bstat.store_done = (state_reg == ST_CPLD) && load_ok && k_last;
    assign bstat.stg_re     = (state_reg == ST_CPRD);
    assign bstat.stg_addr   = k_reg;

    // zero acts as one, above the table size acts as the table size
    always_comb begin
        if (keep_reg == '0) begin
            lim = CNT_W'(1);
        end else if (32'(keep_reg) > 32'(nrfs_pkg::SLOTS)) begin
            lim = CNT_W'(nrfs_pkg::SLOTS);
        end else begin
            lim = CNT_W'(keep_reg);
        end
    end

    // slot for a new frame: its own, a free one, or the smallest if larger
    always_comb begin
        sel_ok  = 1'b0;
        sel_new = 1'b0;
        sel_idx = min_idx_reg;
        if (hit_v_reg) begin
            sel_ok  = 1'b1;
            sel_idx = hit_idx_reg;
        end else if (free_v_reg) begin
            sel_ok  = 1'b1;
            sel_new = 1'b1;
            sel_idx = free_idx_reg;
        end else if (min_v_reg && (cmd_reg.seq > min_seq_reg)) begin
            sel_ok  = 1'b1;
        end
    end

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = clr_idx_reg;
        slot_wdata = '0;
        slot_re    = 1'b0;
        frame_we   = 1'b0;
        frame_re   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                slot_we = 1'b1;
            end
            ST_SCAN: begin
                slot_re = (issue_reg < (SLOT_W+1)'(nrfs_pkg::SLOTS));
            end
            ST_DECIDE: begin
                slot_we        = sel_ok;
                slot_waddr     = sel_idx;
                slot_wdata.vld = 1'b1;
                slot_wdata.seq = cmd_reg.seq;
            end
            ST_CPLD: begin
                frame_we = load_ok && store_ok_reg;
            end
            ST_EVDEC: begin
                slot_we        = min_v_reg;
                slot_waddr     = min_idx_reg;
                slot_wdata.vld = 1'b0;
                slot_wdata.seq = min_seq_reg;
            end
            ST_RPRD: begin
                frame_re = 1'b1;
            end
            ST_IDLE, ST_CPRD, ST_EVCHK, ST_RPLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            slot_q <= slot_mem[issue_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_addr] <= stg_q;
        end
        if (frame_re) begin
            frame_q <= frame_mem[frame_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            keep_reg    <= nrfs_pkg::KEEP_RESET;
            out_v_reg   <= 1'b0;
            pipe_v_reg  <= 1'b0;
            evict_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                keep_reg <= cfg_wr_data;
            end
            if (out_load) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == SLOT_W'(nrfs_pkg::SLOTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (fifo_not_empty) begin
                        cmd_reg    <= fifo_head;
                        evict_reg  <= 1'b0;
                        issue_reg  <= '0;
                        pipe_v_reg <= 1'b0;
                        hit_v_reg  <= 1'b0;
                        free_v_reg <= 1'b0;
                        min_v_reg  <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    pipe_v_reg   <= slot_re;
                    pipe_idx_reg <= issue_reg[SLOT_W-1:0];
                    if (slot_re) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (pipe_v_reg) begin
                        if (!hit_v_reg && slot_q.vld && (slot_q.seq == cmd_reg.seq)) begin
                            hit_v_reg   <= 1'b1;
                            hit_idx_reg <= pipe_idx_reg;
                        end
                        if (!free_v_reg && !slot_q.vld) begin
                            free_v_reg   <= 1'b1;
                            free_idx_reg <= pipe_idx_reg;
                        end
                        if (slot_q.vld && (!min_v_reg || (slot_q.seq < min_seq_reg))) begin
                            min_v_reg   <= 1'b1;
                            min_idx_reg <= pipe_idx_reg;
                            min_seq_reg <= slot_q.seq;
                        end
                    end
                    if (scan_done) begin
                        k_reg <= '0;
                        if (evict_reg) begin
                            state_reg <= ST_EVDEC;
                        end else if (cmd_reg.op == nrfs_pkg::OP_REPLAY) begin
                            base_reg  <= FADDR_W'(hit_idx_reg * nrfs_pkg::FRAME_WORDS);
                            state_reg <= hit_v_reg ? ST_RPRD : ST_IDLE;
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    store_ok_reg <= sel_ok;
                    base_reg     <= FADDR_W'(sel_idx * nrfs_pkg::FRAME_WORDS);
                    if (sel_new) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_CPRD;
                end
                ST_CPRD: begin
                    state_reg <= ST_CPLD;
                end
                ST_CPLD: begin
                    if (load_ok) begin
                        out_word_reg   <= stg_q;
                        out_last_reg   <= k_last;
                        out_replay_reg <= 1'b0;
                        k_reg          <= k_reg + 1'b1;
                        state_reg      <= k_last ? ST_EVCHK : ST_CPRD;
                    end
                end
                ST_EVCHK: begin
                    if (count_reg > lim) begin
                        evict_reg  <= 1'b1;
                        issue_reg  <= '0;
                        pipe_v_reg <= 1'b0;
                        hit_v_reg  <= 1'b0;
                        free_v_reg <= 1'b0;
                        min_v_reg  <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EVDEC: begin
                    // drop the smallest entry, then check the limit again
                    if (min_v_reg) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_EVCHK;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RPRD: begin
                    state_reg <= ST_RPLD;
                end
                ST_RPLD: begin
                    if (load_ok) begin
                        out_word_reg   <= frame_q;
                        out_last_reg   <= k_last;
                        out_replay_reg <= 1'b1;
                        k_reg          <= k_reg + 1'b1;
                        state_reg      <= k_last ? ST_IDLE : ST_RPRD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/nack_retransmit_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nack_retransmit_frame_store
// Sender-side retransmission store: forwards and keeps good frames, evicts
// the smallest sequence numbers over the keep limit, replays on NACK.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  input     s_valid/s_ready, s_mode, s_data_word,   in
//            s_frame_end
//  result    m_valid/m_ready, m_out_word,            out
//            m_out_last, m_is_replay
//  config    cfg_wr_en, cfg_wr_data (keep_limit)     in
//
//  A frame word is taken on each accepted handshake. A good frame or a NACK
//  costs one walk of the slot table (one slot read per cycle), then a read
//  state and a load state per emitted word from the staging or frame memory
//  read port, plus one further table walk for each evicted entry.
//  After reset a clearing pass writes all SLOTS (512) entries of the slot
//  table; no request is taken until it ends. A stalled result holds the back
//  part; the front part keeps taking frame words while the request queue
//  has room and no stored frame is still being copied.
// ----------------------------------------------------------------------------
module nack_retransmit_frame_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nrfs_pkg::KEEP_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [31:0]                   s_data_word,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_out_word,
    output logic                          m_out_last,
    output logic                          m_is_replay
);

    logic                 fifo_full;
    logic                 fifo_push;
    nrfs_pkg::cmd_t       fifo_cmd;
    logic                 fifo_pop;
    logic                 fifo_not_empty;
    nrfs_pkg::cmd_t       fifo_head;
    nrfs_pkg::back_stat_t bstat;
    logic [31:0]          stg_q;

    nrfs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_word (s_data_word),
        .s_frame_end (s_frame_end),
        .fifo_full   (fifo_full),
        .fifo_push   (fifo_push),
        .fifo_cmd    (fifo_cmd),
        .bstat       (bstat),
        .stg_q       (stg_q)
    );

    nrfs_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_cmd  (fifo_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    nrfs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fifo_not_empty (fifo_not_empty),
        .fifo_head      (fifo_head),
        .fifo_pop       (fifo_pop),
        .bstat          (bstat),
        .stg_q          (stg_q),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_word     (m_out_word),
        .m_out_last     (m_out_last),
        .m_is_replay    (m_is_replay)
    );

endmodule

@@ hw/rtl/nrfs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_checker
// Port-level checks of the retransmission frame store, bound to the top.
// ----------------------------------------------------------------------------
`include "nack_retransmit_frame_store_assert.svh"

module nrfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [nrfs_pkg::KEEP_W-1:0]   cfg_wr_data,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_mode,
    input logic [31:0]                   s_data_word,
    input logic                          s_frame_end,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [31:0]                   m_out_word,
    input logic                          m_out_last,
    input logic                          m_is_replay
);

    `NRFS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_word) && $stable(m_out_last) && $stable(m_is_replay), "stalled result changed")

    `NRFS_ASSERT(a_kind_steady, aclk, aresetn, m_valid && m_ready && !m_out_last |=> !m_valid || (m_is_replay == $past(m_is_replay)), "frame kind changed within a frame")

    `NRFS_ASSERT_NORST(a_no_req_after_reset, aclk, !aresetn |=> !s_ready, "request taken during table clear")

    `NRFS_ASSERT_NORST(a_no_out_after_reset, aclk, !aresetn |=> !m_valid, "result shown straight after reset")

endmodule

bind nack_retransmit_frame_store nrfs_checker u_nrfs_checker (.*);

@@ sim/nrfs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_scoreboard
// Watches both channels of the frame store, keeps its own copy of the stored
// frames and keep limit, predicts every emitted word and compares in order.
// ----------------------------------------------------------------------------
module nrfs_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_data_word,
    input  logic        s_frame_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_out_word,
    input  logic        m_out_last,
    input  logic        m_is_replay,
    output int          fail_count,
    output int          pending_words,
    output int          frames_out,
    output int          replays_out
);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        replay;
    } out_word_t;

    logic [31:0] stored_frames [nrfs_pkg::SLOTS][nrfs_pkg::FRAME_WORDS];
    logic [31:0] slot_tag [nrfs_pkg::SLOTS];
    logic        slot_used [nrfs_pkg::SLOTS];
    int          used_count;
    logic [31:0] stage [nrfs_pkg::FRAME_WORDS];
    int          stage_idx;
    logic [9:0]  keep_reg;
    out_word_t   expected_words [$];

    function automatic int find_seq(logic [31:0] seq);
        for (int i = 0; i < nrfs_pkg::SLOTS; i++)
            if (slot_used[i] && slot_tag[i] == seq) return i;
        return -1;
    endfunction

    function automatic int smallest_seq_slot();
        int best;
        best = -1;
        for (int i = 0; i < nrfs_pkg::SLOTS; i++)
            if (slot_used[i] && (best < 0 || slot_tag[i] < slot_tag[best])) best = i;
        return best;
    endfunction

    task automatic push_frame_words(int slot, logic replay);
        out_word_t w;
        for (int k = 0; k < nrfs_pkg::FRAME_WORDS; k++) begin
            w.word   = (slot < 0) ? stage[k] : stored_frames[slot][k];
            w.last   = (k == nrfs_pkg::FRAME_WORDS - 1);
            w.replay = replay;
            expected_words.push_back(w);
        end
        frames_out += 1;
    endtask

    task automatic keep_good_frame();
        int s;
        int m;
        int lim;
        s = find_seq(stage[0]);
        if (s < 0) begin
            for (int i = 0; i < nrfs_pkg::SLOTS; i++)
                if (!slot_used[i]) begin
                    s = i;
                    break;
                end
            if (s >= 0) begin
                slot_used[s] = 1'b1;
                used_count++;
            end else begin
                m = smallest_seq_slot();
                if (m >= 0 && stage[0] > slot_tag[m]) s = m;
            end
        end
        if (s >= 0) begin
            slot_tag[s] = stage[0];
            for (int k = 0; k < nrfs_pkg::FRAME_WORDS; k++) stored_frames[s][k] = stage[k];
        end
        lim = (keep_reg == 0) ? 1 : (keep_reg > nrfs_pkg::SLOTS) ? nrfs_pkg::SLOTS : keep_reg;
        while (used_count > lim) begin
            m = smallest_seq_slot();
            slot_used[m] = 1'b0;
            used_count--;
        end
    endtask

    task automatic take_request();
        int s;
        if (s_mode) begin
            s = find_seq(s_data_word);
            if (s >= 0) begin
                push_frame_words(s, 1'b1);
                replays_out += 1;
            end
            return;
        end
        if (stage_idx < nrfs_pkg::FRAME_WORDS) stage[stage_idx] = s_data_word;
        if (stage_idx <= nrfs_pkg::FRAME_WORDS) stage_idx++;
        if (!s_frame_end) return;
        s = stage_idx;
        stage_idx = 0;
        if (s != nrfs_pkg::FRAME_WORDS) return;
        keep_good_frame();
        push_frame_words(-1, 1'b0);
    endtask

    always @(posedge aclk) begin
        out_word_t e;
        if (!aresetn) begin
            for (int i = 0; i < nrfs_pkg::SLOTS; i++) slot_used[i] = 1'b0;
            used_count = 0;
            stage_idx = 0;
            keep_reg = nrfs_pkg::KEEP_RESET;
            expected_words.delete();
            fail_count = 0;
            frames_out = 0;
            replays_out = 0;
        end else begin
            if (cfg_wr_en) keep_reg = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h last %b replay %b", $time,
                             m_out_word, m_out_last, m_is_replay);
                    fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.word !== m_out_word || e.last !== m_out_last
                            || e.replay !== m_is_replay) begin
                        $display("%0t: expected %h/%b/%b, got %h/%b/%b", $time,
                                 e.word, e.last, e.replay,
                                 m_out_word, m_out_last, m_is_replay);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) take_request();
        end
        pending_words = expected_words.size();
    end
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives frames, broken frames and NACKs into the frame store under varying
// keep limits and back-pressure; the scoreboard predicts and compares output.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [31:0] s_data_word = '0;
    logic        s_frame_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_word;
    logic        m_out_last;
    logic        m_is_replay;
    int          fail_count;
    int          pending_words;
    int          frames_out;
    int          replays_out;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_len = 0;
    int          hold_off_cnt = 0;
    logic        hold_off_taken = 1'b0;
    int          requests_sent = 0;
    int          quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    nack_retransmit_frame_store dut (.*);

    nrfs_scoreboard scoreboard_i (.*);

    // Receiver: random stalls plus one long hold-off once it is requested
    always @(posedge aclk) begin
        if (hold_off_cnt > 0) begin
            hold_off_cnt <= hold_off_cnt - 1;
            m_ready <= 1'b0;
        end else if (hold_off_len > 0 && !hold_off_taken) begin
            hold_off_taken <= 1'b1;
            hold_off_cnt <= hold_off_len;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(logic mode, logic [31:0] word, logic last_word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_data_word <= word;
        s_frame_end <= last_word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic send_frame(logic [31:0] seq, int len);
        for (int k = 0; k < len; k++)
            send_request(1'b0, (k == 0) ? seq : $urandom, k == len - 1);
    endtask

    task automatic send_nack(logic [31:0] seq);
        send_request(1'b1, seq, $urandom_range(1));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (8 * nrfs_pkg::SLOTS) @(posedge aclk);
    endtask

    task automatic write_keep(logic [9:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, short/long/one-word frames, NACK hit and miss
        send_idle_pct = 13;
        recv_idle_pct = 74;
        send_frame(32'h0000_0000, nrfs_pkg::FRAME_WORDS);
        // NACK in the middle of a frame leaves assembly intact
        for (int k = 0; k < nrfs_pkg::FRAME_WORDS; k++) begin
            send_request(1'b0, (k == 0) ? 32'hFFFF_FFFF : ~k,
                         k == nrfs_pkg::FRAME_WORDS - 1);
            if (k == 10) send_nack(32'h0000_0000);
        end
        send_nack(32'hFFFF_FFFF);
        send_nack(32'h1234_5678);
        send_frame(32'h5, 3);
        send_frame(32'h6, nrfs_pkg::FRAME_WORDS + 2);
        send_frame(32'h8, 1);
        drain();

        // Keep limit at the bottom: new smaller frame evicts itself
        write_keep(10'd0);
        send_frame(32'h10, nrfs_pkg::FRAME_WORDS);
        send_nack(32'h10);
        send_nack(32'hFFFF_FFFF);
        drain();

        // Long receiver hold-off while frames keep coming
        write_keep(10'd3);
        send_idle_pct = 74;
        recv_idle_pct = 13;
        hold_off_len = 3000;
        send_frame(32'h40, nrfs_pkg::FRAME_WORDS);
        send_frame(32'h41, nrfs_pkg::FRAME_WORDS);
        send_nack(32'h40);
        drain();

        write_keep(10'h3FF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_frame(32'h50, nrfs_pkg::FRAME_WORDS);
        send_nack(32'h41);
        drain();
        write_keep(10'd512);
        send_nack(32'h50);
        send_nack(32'h30);
        drain();

        $display("run: %0d requests, %0d frames emitted, %0d replays",
                 requests_sent, frames_out, replays_out);
        $display("keep limits 0,3,1023,512 exercised with back-pressure and hold-off");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
